// File: hw/rtl/lpd_pkg.sv
// Shared types and constants for the length-prefixed message deframer.
// No dependencies; every other file in hw/rtl refers to this package by scope.
package lpd_pkg;

    localparam int unsigned HEADER_BYTES = 5;
    localparam logic [2:0] HDR_LAST_COUNT = 3'(HEADER_BYTES - 1);
    localparam logic [31:0] LENGTH_SELF = 32'd4;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DISCARD = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } stream_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] message_type;
        logic [7:0] payload_byte;
        logic       first_of_message;
        logic       last_of_message;
    } msg_item_t;

endpackage

// File: hw/rtl/lpd_parse.sv
// Framing state machine: header collection, payload countdown, discard.
// Depends on lpd_pkg for the phase, kind and item types.
module lpd_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  lpd_pkg::stream_item_t item,
    output logic                 res_valid,
    output lpd_pkg::msg_item_t   res
);

    lpd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [7:0]      type_reg, type_next;
    logic [31:0]     len_reg, len_next;
    logic [31:0]     rem_reg, rem_next;
    logic            first_reg, first_next;

    logic [31:0]     len_shifted;

    assign len_shifted = {len_reg[23:0], item.data_byte};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        first_next = first_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.kind         = lpd_pkg::KIND_DATA;
        res.message_type = type_reg;

        case (phase_reg)
            lpd_pkg::PH_DISCARD:
            begin
                if (item.chunk_end)
                begin
                    phase_next = lpd_pkg::PH_HEADER;
                end
            end
            lpd_pkg::PH_PAYLOAD:
            begin
                res_valid            = 1'b1;
                res.payload_byte     = item.data_byte;
                res.first_of_message = first_reg;
                res.last_of_message  = (rem_reg <= 32'd1);
                first_next           = 1'b0;
                if (rem_reg > 32'd1)
                begin
                    rem_next = rem_reg - 32'd1;
                end
                else
                begin
                    rem_next   = '0;
                    phase_next = lpd_pkg::PH_HEADER;
                    first_next = 1'b1;
                end
            end
            default:
            begin
                phase_next = lpd_pkg::PH_HEADER;
                if (cnt_reg == 3'd0)
                begin
                    type_next = item.data_byte;
                    len_next  = '0;
                    cnt_next  = 3'd1;
                end
                else
                begin
                    len_next = len_shifted;
                    if (cnt_reg == lpd_pkg::HDR_LAST_COUNT)
                    begin
                        cnt_next   = 3'd0;
                        first_next = 1'b1;
                        if (len_shifted < lpd_pkg::LENGTH_SELF)
                        begin
                            // drop the rest of the chunk unless this byte ends it
                            res_valid  = 1'b1;
                            res.kind   = lpd_pkg::KIND_ERROR;
                            phase_next = item.chunk_end ? lpd_pkg::PH_HEADER
                                                        : lpd_pkg::PH_DISCARD;
                        end
                        else if (len_shifted == lpd_pkg::LENGTH_SELF)
                        begin
                            res_valid           = 1'b1;
                            res.kind            = lpd_pkg::KIND_EMPTY;
                            res.last_of_message = 1'b1;
                        end
                        else
                        begin
                            rem_next   = len_shifted - lpd_pkg::LENGTH_SELF;
                            phase_next = lpd_pkg::PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lpd_pkg::PH_HEADER;
            cnt_reg   <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            first_reg <= first_next;
        end
    end

`ifndef SYNTHESIS
    a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lpd_pkg::PH_PAYLOAD) |-> (rem_reg != 32'd0))
        else $error("payload phase with no bytes remaining");

    a_count_only_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 3'd0) |-> (phase_reg == lpd_pkg::PH_HEADER))
        else $error("header count set outside header phase");
`endif

endmodule

// File: hw/rtl/lpd_out_buf.sv
// Two-entry result buffer (output register plus skid register).
// Depends on lpd_pkg for the result item type.
module lpd_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lpd_pkg::msg_item_t push_item,
    output logic               full,
    output logic               msg_valid,
    input  logic               msg_stall,
    output lpd_pkg::msg_item_t msg_item
);

    logic               out_vld_reg, out_vld_next;
    logic               skid_vld_reg, skid_vld_next;
    lpd_pkg::msg_item_t out_reg, out_next;
    lpd_pkg::msg_item_t skid_reg, skid_next;
    logic               pop;

    assign pop       = out_vld_reg && !msg_stall;
    assign full      = skid_vld_reg;
    assign msg_valid = out_vld_reg;
    assign msg_item  = out_reg;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        out_next      = out_reg;
        skid_next     = skid_reg;
        if (pop)
        begin
            if (skid_vld_reg)
            begin
                // advance the held result into the output register
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = push;
                out_next     = push_item;
            end
        end
        else if (push)
        begin
            if (!out_vld_reg)
            begin
                out_vld_next = 1'b1;
                out_next     = push_item;
            end
            else
            begin
                skid_vld_next = 1'b1;
                skid_next     = push_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry held with empty output register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_vld_reg)
        else $error("result pushed into a full buffer");
`endif

endmodule

// File: hw/rtl/length_prefixed_message_deframer.sv
// Length-prefixed message deframer: one input register, the framing logic
// and the result buffer. Depends on lpd_pkg, lpd_parse and lpd_out_buf.
//
// Usage:
//   The stream channel (stream_valid, stream_stall, stream_item) carries one
//   received byte per transfer, with chunk_end set on the last byte of a chunk.
//   Each message is a type byte, a 4-byte big-endian length that counts
//   itself, then the payload. The msg channel (msg_valid, msg_stall, msg_item)
//   delivers one result per payload byte, one empty-message result for a
//   length of four, or one error result for a length below four; after an
//   error, bytes are dropped through the next chunk_end byte.
//   Header bytes other than the last, and dropped bytes, give no result.
//   A transferred byte is held in the input register; its result is then
//   registered in the result buffer and shown on msg_item.
//   Throughput: one byte per cycle, sustained, while msg_stall stays low.
//   When the receiver stalls, the result buffer holds up to two results;
//   stream_stall rises only when both are occupied and a byte is waiting.
//   Reset clears the framing state to the start of a header and empties
//   every register stage.
module length_prefixed_message_deframer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   stream_valid,
    output logic                   stream_stall,
    input  lpd_pkg::stream_item_t  stream_item,
    output logic                   msg_valid,
    input  logic                   msg_stall,
    output lpd_pkg::msg_item_t     msg_item
);

    logic                  in_vld_reg;
    lpd_pkg::stream_item_t in_reg;
    logic                  buf_full;
    logic                  take;
    logic                  res_valid;
    lpd_pkg::msg_item_t    res;

    assign take         = in_vld_reg && !buf_full;
    assign stream_stall = in_vld_reg && buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!stream_stall)
        begin
            in_vld_reg <= stream_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stream_stall && stream_valid)
        begin
            in_reg <= stream_item;
        end
    end

    lpd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (in_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    lpd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && res_valid),
        .push_item (res),
        .full      (buf_full),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_item  (msg_item)
    );

`ifndef SYNTHESIS
    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        stream_stall |=> in_vld_reg && $stable(in_reg))
        else $error("waiting input byte lost while stalled");
`endif

endmodule

// File: tb/length_prefixed_message_deframer_test.sv
// Self-checking testbench for length_prefixed_message_deframer: sends framed byte streams,
// predicts every result with its own framing model and checks each msg transfer in order.
// Depends on lpd_pkg and the deframer RTL.
`timescale 1ns / 100ps

module length_prefixed_message_deframer_test;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned QUIET_TAIL = 200;
    localparam int unsigned HOLD_OFF_CYCLES = 150;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_PRINTED = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  stream_valid;
    logic                  stream_stall;
    lpd_pkg::stream_item_t stream_item;
    logic                  msg_valid;
    logic                  msg_stall;
    lpd_pkg::msg_item_t    msg_item;

    // framing model state
    lpd_pkg::phase_t framing_phase;
    logic [2:0]      header_taken;
    logic [7:0]      type_hold;
    logic [31:0]     length_acc;
    logic [31:0]     payload_left;
    logic            first_pending;

    lpd_pkg::msg_item_t expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned framed_items = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;
    bit          hold_off_req = 1'b0;

    length_prefixed_message_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_stall (stream_stall),
        .stream_item  (stream_item),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg_item     (msg_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic chance(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Advance the framing model by one accepted byte; queue the result it causes.
    task automatic frame_byte(input lpd_pkg::stream_item_t it);
        lpd_pkg::msg_item_t res;
        res = '0;
        res.message_type = type_hold;
        case (framing_phase)
            lpd_pkg::PH_DISCARD:
            begin
                if (it.chunk_end)
                    framing_phase = lpd_pkg::PH_HEADER;
            end
            lpd_pkg::PH_PAYLOAD:
            begin
                res.kind = lpd_pkg::KIND_DATA;
                res.payload_byte = it.data_byte;
                res.first_of_message = first_pending;
                res.last_of_message = (payload_left <= 1);
                expected_results.push_back(res);
                first_pending = 1'b0;
                if (payload_left > 0)
                    payload_left--;
                if (payload_left == 0)
                begin
                    framing_phase = lpd_pkg::PH_HEADER;
                    first_pending = 1'b1;
                end
            end
            default:
            begin
                framing_phase = lpd_pkg::PH_HEADER;
                if (header_taken == 0)
                begin
                    type_hold = it.data_byte;
                    length_acc = '0;
                    header_taken = 3'd1;
                end
                else
                begin
                    length_acc = {length_acc[23:0], it.data_byte};
                    header_taken = header_taken + 3'd1;
                    if (header_taken == lpd_pkg::HEADER_BYTES)
                    begin
                        header_taken = '0;
                        first_pending = 1'b1;
                        if (length_acc < lpd_pkg::LENGTH_SELF)
                        begin
                            res.kind = lpd_pkg::KIND_ERROR;
                            expected_results.push_back(res);
                            framing_phase = it.chunk_end ? lpd_pkg::PH_HEADER
                                                         : lpd_pkg::PH_DISCARD;
                        end
                        else if (length_acc == lpd_pkg::LENGTH_SELF)
                        begin
                            res.kind = lpd_pkg::KIND_EMPTY;
                            res.last_of_message = 1'b1;
                            expected_results.push_back(res);
                        end
                        else
                        begin
                            payload_left = length_acc - lpd_pkg::LENGTH_SELF;
                            framing_phase = lpd_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
        endcase
    endtask

    // Offer one byte, with an optional gap first; hold it until the transfer.
    task automatic send_byte(input logic [7:0] value, input logic cend);
        lpd_pkg::stream_item_t it;
        it.data_byte = value;
        it.chunk_end = cend;
        if (sender_idle_pct != 0 && chance(sender_idle_pct))
        begin
            stream_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        stream_valid <= 1'b1;
        stream_item <= it;
        do @(posedge clk); while (stream_stall);
        if (framing_phase != lpd_pkg::PH_DISCARD)
            framed_items++;
        frame_byte(it);
    endtask

    task automatic send_message(input logic [7:0] mtype, input logic [31:0] frame_len,
                                input int unsigned payload_count, input int unsigned mark_pct);
        send_byte(mtype, chance(mark_pct));
        for (int i = 3; i >= 0; i--)
            send_byte(frame_len[8*i +: 8], chance(mark_pct));
        for (int unsigned i = 0; i < payload_count; i++)
            send_byte(8'($urandom), chance(mark_pct));
    endtask

    // Header with a length below four; drop_count bytes follow, the last one ends the chunk.
    task automatic send_bad_length(input logic [7:0] mtype, input logic [1:0] bad_len,
                                   input int unsigned drop_count);
        send_byte(mtype, chance(30));
        send_byte(8'h00, chance(30));
        send_byte(8'h00, chance(30));
        send_byte(8'h00, chance(30));
        send_byte({6'b0, bad_len}, drop_count == 0);
        for (int unsigned i = 1; i <= drop_count; i++)
            send_byte(8'($urandom), i == drop_count);
    endtask

    task automatic test_empty_message();
        sender_idle_pct = 30;
        receiver_idle_pct = 30;
        send_message(8'hFF, lpd_pkg::LENGTH_SELF, 0, 0);
    endtask

    // chunk_end on every byte must not disturb header or payload
    task automatic test_single_byte_marked();
        send_message(8'h00, lpd_pkg::LENGTH_SELF + 1, 1, 100);
    endtask

    task automatic test_error_on_chunk_end();
        send_bad_length(8'h5A, 2'd3, 0);
    endtask

    task automatic test_error_discard();
        send_bad_length(8'hA5, 2'd0, 3);
    endtask

    // Hold off the receiver while a long message streams in at full rate.
    task automatic test_back_pressure();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        hold_off_req = 1'b1;
        send_message(8'h3C, lpd_pkg::LENGTH_SELF + 40, 40, 0);
    endtask

    task automatic test_random_stream();
        int unsigned pick;
        framed_items = 0;
        while (framed_items < RANDOM_ITEMS)
        begin
            if (framed_items > RANDOM_ITEMS - QUIET_TAIL)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            else
            begin
                sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                receiver_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
                send_bad_length(8'($urandom), 2'($urandom), $urandom_range(0, 6));
            else if (pick < 20)
                send_message(8'($urandom), lpd_pkg::LENGTH_SELF, 0, 10);
            else if (pick < 23)
                send_message(8'($urandom), lpd_pkg::LENGTH_SELF + 200, 200, 10);
            else
            begin
                pick = $urandom_range(1, 16);
                send_message(8'($urandom), lpd_pkg::LENGTH_SELF + pick, pick, 10);
            end
        end
    endtask

    // Largest length: the message never ends, so every byte is a plain payload byte.
    task automatic test_endless_message();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        send_message(8'h81, 32'hFFFF_FFFF, 20, 20);
    endtask

    always @(posedge clk)
    begin : check_results
        lpd_pkg::msg_item_t want;
        if (rst_n && msg_valid && !msg_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                if (msg_item.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", msg_item.kind, want.kind));
                if (msg_item.message_type !== want.message_type)
                    report_mismatch($sformatf("message_type %02h, want %02h",
                                              msg_item.message_type, want.message_type));
                if (msg_item.payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %02h, want %02h",
                                              msg_item.payload_byte, want.payload_byte));
                if (msg_item.first_of_message !== want.first_of_message)
                    report_mismatch($sformatf("first_of_message %b, want %b",
                                              msg_item.first_of_message,
                                              want.first_of_message));
                if (msg_item.last_of_message !== want.last_of_message)
                    report_mismatch($sformatf("last_of_message %b, want %b",
                                              msg_item.last_of_message,
                                              want.last_of_message));
            end
        end
    end

    initial
    begin : receiver_stalls
        msg_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                msg_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                msg_stall <= 1'b0;
            end
            else if (receiver_idle_pct != 0 && chance(receiver_idle_pct))
            begin
                msg_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                msg_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        stream_valid <= 1'b0;
        stream_item <= '0;
        framing_phase = lpd_pkg::PH_HEADER;
        header_taken = '0;
        type_hold = '0;
        length_acc = '0;
        payload_left = '0;
        first_pending = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_single_byte_marked();
        test_error_on_chunk_end();
        test_error_discard();
        test_back_pressure();
        test_random_stream();
        test_endless_message();

        stream_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
